@@ sv/hrl_pkg.sv @@
// Shared types, codes and character tables for the HTTP request line parser.
// No dependencies; every other file in this folder refers to it by scoped names.
package hrl_pkg;

    localparam int HRL_LEN_BITS_DEF = 12;
    localparam int HRL_CFG_W        = 12;
    localparam int HRL_ADDR_W       = 3;
    localparam int HRL_DATA_W       = 32;

    localparam logic [HRL_CFG_W-1:0] HRL_MAX_LEN_RST = 12'd2048;

    // Register index, taken from the word address bits of paddr.
    localparam logic REG_MAX_SEGMENT_LEN = 1'b0;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam int HRL_NUM_METH = 3;
    localparam int HRL_VER_LEN  = 8;

    localparam logic [7:0] HRL_METH_TEXT [HRL_NUM_METH][8] = '{
        '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00}
    };
    localparam logic [2:0] HRL_METH_LEN [HRL_NUM_METH] = '{3'd3, 3'd4, 3'd6};
    localparam logic [7:0] HRL_VER_TEXT [HRL_VER_LEN] = '{
        8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31
    };

    typedef enum logic [2:0] {
        ROLE_METHOD,
        ROLE_PATH,
        ROLE_QUERY,
        ROLE_VERSION,
        ROLE_DELIM
    } t_role;

    typedef enum logic [2:0] {
        ST_PROGRESS,
        ST_COMPLETE,
        ST_BAD,
        ST_LONG,
        ST_IGNORED
    } t_status;

    typedef enum logic [1:0] {
        METH_NONE,
        METH_GET,
        METH_POST,
        METH_DELETE
    } t_method;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  byte_echo;
        logic [2:0]  byte_role;
        logic [2:0]  status;
        logic [1:0]  method_code;
        logic [11:0] segment_len;
    } t_out_beat;

    function automatic logic uri_char_ok(input logic [7:0] b);
        return b inside {8'h21, [8'h23:8'h24], [8'h26:8'h3B], 8'h3D, [8'h3F:8'h5B],
                         8'h5D, 8'h5F, [8'h61:8'h7A], 8'h7E};
    endfunction

endpackage

@@ sv/hrl_cfg.sv @@
// APB-style configuration register holding the segment length limit.
// Depends on hrl_pkg for widths, the register index and the reset value.
module hrl_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hrl_pkg::HRL_ADDR_W-1:0]   paddr,
    input  logic [hrl_pkg::HRL_DATA_W-1:0]   pwdata,
    output logic [hrl_pkg::HRL_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [hrl_pkg::HRL_CFG_W-1:0]    o_max_len
);

    logic [hrl_pkg::HRL_CFG_W-1:0] r_max_len;
    logic                          sel_max_len;

    assign sel_max_len = (paddr[2] == hrl_pkg::REG_MAX_SEGMENT_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= hrl_pkg::HRL_MAX_LEN_RST;
        end else if (psel && penable && pwrite && sel_max_len) begin
            r_max_len <= pwdata[hrl_pkg::HRL_CFG_W-1:0];
        end
    end

    assign prdata    = sel_max_len ? hrl_pkg::HRL_DATA_W'(r_max_len) : '0;
    assign pready    = 1'b1;
    assign o_max_len = r_max_len;

endmodule

@@ sv/hrl_step.sv @@
// Parse state registers and the per-byte classification and check logic.
// Depends on hrl_pkg for beat types, codes and character tables.
module hrl_step #(
    parameter int LEN_BITS = hrl_pkg::HRL_LEN_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  hrl_pkg::t_in_beat             i_beat,
    input  logic [hrl_pkg::HRL_CFG_W-1:0] i_max_len,
    output hrl_pkg::t_out_beat            o_result
);

    localparam int CW = (LEN_BITS > hrl_pkg::HRL_CFG_W) ? LEN_BITS : hrl_pkg::HRL_CFG_W;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_URI,
        PH_VERSION,
        PH_EOL,
        PH_DONE,
        PH_BAD,
        PH_LONG
    } t_phase;

    t_phase                r_phase, n_phase, s_phase;
    logic [LEN_BITS-1:0]   r_cnt, n_cnt, s_cnt;
    logic [2:0]            r_cand, n_cand, s_cand;
    hrl_pkg::t_method      r_found, n_found, s_found;
    logic                  r_inq, n_inq, s_inq;

    hrl_pkg::t_role        role;
    hrl_pkg::t_status      status;
    hrl_pkg::t_method      code;
    logic [LEN_BITS-1:0]   seg;
    logic [CW-1:0]         seg_ext;
    logic                  overlong;
    logic [7:0]            b;

    assign b = i_beat.data_byte;

    // A restart beat sees the cleared state.
    always_comb begin
        if (i_beat.restart) begin
            s_phase = PH_METHOD;
            s_cnt   = '0;
            s_cand  = 3'b111;
            s_found = hrl_pkg::METH_NONE;
            s_inq   = 1'b0;
        end else begin
            s_phase = r_phase;
            s_cnt   = r_cnt;
            s_cand  = r_cand;
            s_found = r_found;
            s_inq   = r_inq;
        end
    end

    // The limit in force is the register value capped at the all-ones count.
    assign overlong = (CW'(s_cnt) >= CW'(i_max_len)) || (&s_cnt);

    always_comb begin
        n_phase = s_phase;
        n_cnt   = s_cnt;
        n_cand  = s_cand;
        n_found = s_found;
        n_inq   = s_inq;
        role    = hrl_pkg::ROLE_DELIM;
        status  = hrl_pkg::ST_PROGRESS;
        seg     = '0;
        code    = hrl_pkg::METH_NONE;
        case (s_phase)
            PH_METHOD: begin
                if (b == hrl_pkg::CH_SPACE) begin
                    for (int k = 0; k < hrl_pkg::HRL_NUM_METH; k++) begin
                        if (s_cand[k] && s_cnt == LEN_BITS'(hrl_pkg::HRL_METH_LEN[k])) begin
                            code = hrl_pkg::t_method'(2'(k + 1));
                        end
                    end
                    seg = s_cnt;
                    if (code == hrl_pkg::METH_NONE) begin
                        status  = hrl_pkg::ST_BAD;
                        n_phase = PH_BAD;
                    end else begin
                        n_found = code;
                        n_phase = PH_URI;
                        n_cnt   = '0;
                    end
                end else begin
                    role = hrl_pkg::ROLE_METHOD;
                    for (int k = 0; k < hrl_pkg::HRL_NUM_METH; k++) begin
                        if (s_cnt >= LEN_BITS'(hrl_pkg::HRL_METH_LEN[k]) ||
                            hrl_pkg::HRL_METH_TEXT[k][s_cnt[2:0]] != b) begin
                            n_cand[k] = 1'b0;
                        end
                    end
                    if (s_cnt < LEN_BITS'(7)) begin
                        n_cnt = s_cnt + 1'b1;
                    end
                    seg = n_cnt;
                    if (n_cand == 3'b000) begin
                        status  = hrl_pkg::ST_BAD;
                        n_phase = PH_BAD;
                    end
                end
            end
            PH_URI: begin
                if (b == hrl_pkg::CH_SPACE && !(!s_inq && s_cnt == '0)) begin
                    seg     = s_cnt;
                    n_phase = PH_VERSION;
                    n_cnt   = '0;
                end else if (b == hrl_pkg::CH_QMARK && !s_inq && s_cnt != '0) begin
                    seg   = s_cnt;
                    n_inq = 1'b1;
                    n_cnt = '0;
                end else begin
                    role = s_inq ? hrl_pkg::ROLE_QUERY : hrl_pkg::ROLE_PATH;
                    if (overlong) begin
                        seg     = s_cnt;
                        status  = hrl_pkg::ST_LONG;
                        n_phase = PH_LONG;
                    end else if (!hrl_pkg::uri_char_ok(b) ||
                                 (!s_inq && s_cnt == '0 && b != hrl_pkg::CH_SLASH)) begin
                        seg     = s_cnt;
                        status  = hrl_pkg::ST_BAD;
                        n_phase = PH_BAD;
                    end else begin
                        n_cnt = s_cnt + 1'b1;
                        seg   = n_cnt;
                    end
                end
            end
            PH_VERSION: begin
                role = hrl_pkg::ROLE_VERSION;
                if (s_cnt >= LEN_BITS'(hrl_pkg::HRL_VER_LEN) ||
                    hrl_pkg::HRL_VER_TEXT[s_cnt[2:0]] != b) begin
                    seg     = s_cnt;
                    status  = hrl_pkg::ST_BAD;
                    n_phase = PH_BAD;
                end else begin
                    seg = s_cnt + 1'b1;
                    if (s_cnt == LEN_BITS'(hrl_pkg::HRL_VER_LEN - 1)) begin
                        n_phase = PH_EOL;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = s_cnt + 1'b1;
                    end
                end
            end
            PH_EOL: begin
                if (b == hrl_pkg::CH_CR && s_cnt == '0) begin
                    n_cnt = LEN_BITS'(1);
                end else if (b == hrl_pkg::CH_LF) begin
                    status  = hrl_pkg::ST_COMPLETE;
                    n_phase = PH_DONE;
                    n_cnt   = '0;
                end else begin
                    status  = hrl_pkg::ST_BAD;
                    n_phase = PH_BAD;
                end
            end
            PH_DONE: begin
                status = hrl_pkg::ST_IGNORED;
            end
            PH_LONG: begin
                status = hrl_pkg::ST_LONG;
            end
            default: begin
                status  = hrl_pkg::ST_BAD;
                n_phase = PH_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_cnt   <= '0;
            r_cand  <= 3'b111;
            r_found <= hrl_pkg::METH_NONE;
            r_inq   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_cand  <= n_cand;
            r_found <= n_found;
            r_inq   <= n_inq;
        end
    end

    assign seg_ext = CW'(seg);

    always_comb begin
        o_result.byte_echo   = b;
        o_result.byte_role   = role;
        o_result.status      = status;
        o_result.method_code = n_found;
        o_result.segment_len = seg_ext[hrl_pkg::HRL_CFG_W-1:0];
    end

endmodule

@@ sv/http_request_line_parser.sv @@
// HTTP/1.1 request line parser: one byte beat in, one result beat out.
// Throughput is 1 beat per cycle while the result beat is not stalled.
// The input register feeds one stage of parse logic that writes the result register.
// Synchronous active-low reset clears the parse state, both valid flags and sets the limit to 2048.
// Depends on hrl_pkg, hrl_cfg and hrl_step.
module http_request_line_parser #(
    parameter int LEN_BITS = hrl_pkg::HRL_LEN_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  hrl_pkg::t_in_beat              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output hrl_pkg::t_out_beat             o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hrl_pkg::HRL_ADDR_W-1:0] paddr,
    input  logic [hrl_pkg::HRL_DATA_W-1:0] pwdata,
    output logic [hrl_pkg::HRL_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic                          r_in_valid;
    hrl_pkg::t_in_beat             r_in_data;
    logic                          r_out_valid;
    hrl_pkg::t_out_beat            r_out_data;
    logic                          out_hold;
    logic                          advance;
    logic                          accept;
    logic [hrl_pkg::HRL_CFG_W-1:0] max_len;
    hrl_pkg::t_out_beat            result;

    assign out_hold   = r_out_valid && i_out_stall;
    assign advance    = r_in_valid && !out_hold;
    assign o_in_stall = r_in_valid && out_hold;
    assign accept     = i_in_valid && !o_in_stall;

    hrl_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    hrl_step #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_beat    (r_in_data),
        .i_max_len (max_len),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= accept || (r_in_valid && !advance);
            r_out_valid <= advance || out_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ sv/hrl_checker.sv @@
// Port-level checks for the HTTP request line parser, bound to its top level.
// Depends on hrl_pkg for payload types and codes.
module hrl_port_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input hrl_pkg::t_out_beat             o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result beat");

    a_complete_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == hrl_pkg::ST_COMPLETE |->
            o_out_data.byte_role == hrl_pkg::ROLE_DELIM && o_out_data.segment_len == '0 &&
            o_out_data.byte_echo == hrl_pkg::CH_LF && o_out_data.method_code != hrl_pkg::METH_NONE)
        else $error("line complete beat is not a bare LF after a method");

    a_ignored_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == hrl_pkg::ST_IGNORED |->
            o_out_data.byte_role == hrl_pkg::ROLE_DELIM && o_out_data.segment_len == '0)
        else $error("ignored beat carries a role or a length");

    a_method_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_role == hrl_pkg::ROLE_METHOD |->
            o_out_data.method_code == hrl_pkg::METH_NONE)
        else $error("method code set while still inside the method token");

endmodule

bind http_request_line_parser hrl_port_checker u_hrl_checker (.*);
